// ----- design/mcr_pkg.sv -----
// ----------------------------------------------------------------------------
// mcr_pkg: shared definitions for the midpoint circle rasterizer
// Widths, state encoding and controller/datapath command and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package mcr_pkg;

  localparam int unsigned COORD_BITS_DEF  = 13;
  localparam int unsigned RADIUS_BITS_DEF = 6;
  localparam int unsigned CENTER_BITS     = 12;
  // wide enough for center +/- offset without overflow
  localparam int unsigned SUM_BITS        = 14;
  localparam int unsigned NUM_POINTS      = 8;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic load;  // capture a new request
    logic step;  // emit one iteration and advance the offsets
  } cmd_t;

  typedef struct packed {
    logic last;  // current iteration is the final one of the circle
  } sts_t;

endpackage

`default_nettype wire

// ----- design/mcr_req_if.sv -----
// ----------------------------------------------------------------------------
// mcr_req_if: circle request channel
// Valid/ready channel carrying center and radius of one circle.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcr_req_if
  import mcr_pkg::*;
#(
  parameter int unsigned RADIUS_BITS = RADIUS_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [CENTER_BITS-1:0] center_x;
  logic signed [CENTER_BITS-1:0] center_y;
  logic        [RADIUS_BITS-1:0] radius;

  modport source (output valid, output center_x, output center_y, output radius,
                  input ready);
  modport sink   (input valid, input center_x, input center_y, input radius,
                  output ready);
endinterface

`default_nettype wire

// ----- design/mcr_res_if.sv -----
// ----------------------------------------------------------------------------
// mcr_res_if: rasterized point channel
// Valid/ready channel carrying the eight mirrored points of one iteration.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcr_res_if
  import mcr_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [2*COORD_BITS-1:0] point_0;
  logic [2*COORD_BITS-1:0] point_1;
  logic [2*COORD_BITS-1:0] point_2;
  logic [2*COORD_BITS-1:0] point_3;
  logic [2*COORD_BITS-1:0] point_4;
  logic [2*COORD_BITS-1:0] point_5;
  logic [2*COORD_BITS-1:0] point_6;
  logic [2*COORD_BITS-1:0] point_7;
  logic                    last_step;

  modport source (output valid, output point_0, output point_1, output point_2,
                  output point_3, output point_4, output point_5, output point_6,
                  output point_7, output last_step, input ready);
  modport sink   (input valid, input point_0, input point_1, input point_2,
                  input point_3, input point_4, input point_5, input point_6,
                  input point_7, input last_step, output ready);
endinterface

`default_nettype wire

// ----- design/mcr_datapath.sv -----
// ----------------------------------------------------------------------------
// mcr_datapath: offset/error registers and point generation
// Holds the loop state, computes one midpoint update per step and registers
// the eight mirrored points as the result payload.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_datapath
  import mcr_pkg::*;
#(
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cmd_t                          cmd_i,
  output      sts_t                          sts_o,
  input  wire logic signed [CENTER_BITS-1:0] center_x_i,
  input  wire logic signed [CENTER_BITS-1:0] center_y_i,
  input  wire logic        [RADIUS_BITS-1:0] radius_i,
  output      logic [2*COORD_BITS-1:0]       point_o [NUM_POINTS],
  output      logic                          last_step_o
);

  localparam int unsigned OFS_BITS = RADIUS_BITS + 2;
  localparam int unsigned ERR_BITS = RADIUS_BITS + 4;
  localparam int unsigned EXT_BITS = (COORD_BITS > SUM_BITS) ? COORD_BITS : SUM_BITS;

  logic signed [OFS_BITS-1:0]    x_q, x_d, y_q, y_d;
  logic signed [ERR_BITS-1:0]    err_q, err_d, err_mid;
  logic signed [CENTER_BITS-1:0] cx_q, cy_q;
  logic [2*COORD_BITS-1:0]       point_q [NUM_POINTS];
  logic [2*COORD_BITS-1:0]       point_d [NUM_POINTS];
  logic                          last_q;
  logic                          err_le_zero, mid_gt_zero, last_d;

  logic signed [SUM_BITS-1:0] cxe, cye, xe, ye;

  // wrap or sign-extend a coordinate to the output width
  function automatic logic [COORD_BITS-1:0] fit(input logic signed [SUM_BITS-1:0] v);
    logic signed [EXT_BITS-1:0] e;
    e = EXT_BITS'(v);
    return e[COORD_BITS-1:0];
  endfunction

  // midpoint update: a conditional y step first, then a conditional x step
  always_comb begin
    err_le_zero = err_q[ERR_BITS-1] || (err_q == '0);
    y_d         = err_le_zero ? y_q + OFS_BITS'(1) : y_q;
    err_mid     = err_le_zero ? err_q + ERR_BITS'({y_d, 1'b1}) : err_q;
    mid_gt_zero = !err_mid[ERR_BITS-1] && (err_mid != '0);
    x_d         = mid_gt_zero ? x_q - OFS_BITS'(1) : x_q;
    err_d       = mid_gt_zero ? err_mid - ERR_BITS'($signed({x_d, 1'b1})) : err_mid;
    last_d      = (x_d < y_d);
  end

  always_comb begin
    cxe = SUM_BITS'(cx_q);
    cye = SUM_BITS'(cy_q);
    xe  = SUM_BITS'(x_q);
    ye  = SUM_BITS'(y_q);
    point_d[0] = {fit(cye + ye), fit(cxe + xe)};
    point_d[1] = {fit(cye + xe), fit(cxe + ye)};
    point_d[2] = {fit(cye + xe), fit(cxe - ye)};
    point_d[3] = {fit(cye + ye), fit(cxe - xe)};
    point_d[4] = {fit(cye - ye), fit(cxe - xe)};
    point_d[5] = {fit(cye - xe), fit(cxe - ye)};
    point_d[6] = {fit(cye - xe), fit(cxe + ye)};
    point_d[7] = {fit(cye - ye), fit(cxe + xe)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      y_q   <= '0;
      err_q <= '0;
      cx_q  <= '0;
      cy_q  <= '0;
    end else if (cmd_i.load) begin
      x_q   <= OFS_BITS'(radius_i);
      y_q   <= '0;
      err_q <= '0;
      cx_q  <= center_x_i;
      cy_q  <= center_y_i;
    end else if (cmd_i.step) begin
      x_q   <= x_d;
      y_q   <= y_d;
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      point_q <= point_d;
      last_q  <= last_d;
    end
  end

  assign sts_o.last  = last_d;
  assign point_o     = point_q;
  assign last_step_o = last_q;

endmodule

`default_nettype wire

// ----- design/mcr_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcr_ctrl: request sequencer
// Accepts a request when idle, steps the datapath once per free output slot
// and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_ctrl
  import mcr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output      logic req_ready_o,
  output      logic res_valid_o,
  input  wire logic res_ready_i,
  input  wire sts_t sts_i,
  output      cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    out_free    = !out_valid_q || res_ready_i;
    out_valid_d = out_valid_q && !res_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (out_free) begin
          cmd_o.step  = 1'b1;
          out_valid_d = 1'b1;
          if (sts_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_load_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_RUN)
    else $error("request accepted but sequencer did not start");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_ready_i |-> !cmd_o.step)
    else $error("stalled result overwritten");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step && sts_i.last |=> state_q == ST_IDLE && out_valid_q)
    else $error("final iteration did not return to idle");
  a_no_load_and_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && cmd_o.step))
    else $error("load and step issued together");
`endif

endmodule

`default_nettype wire

// ----- design/midpoint_circle_rasterizer.sv -----
// An accepted request is loaded; run steps then register its results.
// Throughput: one result per cycle while the sink is ready; a circle of radius r
//   gives N = (iterations while x >= y) results, at most 45 for r = 63, and the
//   next request is taken once the sequencer is back in idle.
// The single datapath update per cycle (y step, then x step) sets this rate.
// Reset: asynchronous, clears the sequencer, result valid and loop registers.
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer: top level
// Turns a circle request into one result per midpoint iteration, each with the
// eight octant-mirrored points and a flag on the final iteration.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_circle_rasterizer
  import mcr_pkg::*;
#(
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = RADIUS_BITS_DEF
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  mcr_req_if.sink  req_i,
  mcr_res_if.source res_o
);

  cmd_t                    cmd;
  sts_t                    sts;
  logic [2*COORD_BITS-1:0] point [NUM_POINTS];

  // Sequencer: idle accepts a request, run steps whenever the result slot is
  // free (empty, or being taken this cycle), so a new request can be accepted
  // while the final result of the previous circle still waits at the output.
  mcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: offsets, decision error, held center and the result register.
  mcr_datapath #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .center_x_i  (req_i.center_x),
    .center_y_i  (req_i.center_y),
    .radius_i    (req_i.radius),
    .point_o     (point),
    .last_step_o (res_o.last_step)
  );

  // Spread the point array over the named result fields.
  assign res_o.point_0 = point[0];
  assign res_o.point_1 = point[1];
  assign res_o.point_2 = point[2];
  assign res_o.point_3 = point[3];
  assign res_o.point_4 = point[4];
  assign res_o.point_5 = point[5];
  assign res_o.point_6 = point[6];
  assign res_o.point_7 = point[7];

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the midpoint circle rasterizer
// Sends circle requests over the request channel, works out every midpoint
// iteration of each circle in a local model, and compares the eight mirrored
// points and the final-iteration flag of each result in order of arrival.
// ----------------------------------------------------------------------------

module tb;
  import mcr_pkg::*;

  localparam int unsigned CB = COORD_BITS_DEF;
  localparam int unsigned RB = RADIUS_BITS_DEF;

  // One midpoint iteration as the block should report it.
  typedef struct packed {
    logic [NUM_POINTS-1:0][2*CB-1:0] pts;
    logic                            last;
  } circle_step_t;

  logic clk;
  logic rst_n;
  logic steady_flow;  // when set, neither side idles
  int   fail_count;

  circle_step_t expected_steps[$];

  mcr_req_if #(.RADIUS_BITS(RB)) req ();
  mcr_res_if #(.COORD_BITS(CB))  res ();

  midpoint_circle_rasterizer #(
    .COORD_BITS (CB),
    .RADIUS_BITS(RB)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .res_o (res)
  );

  always #5 clk = ~clk;

  // Pack a point: x in the low half, y in the high half, each wrapped to the
  // coordinate width.
  function automatic logic [2*CB-1:0] pack_xy(input int px, input int py);
    logic [CB-1:0] xw;
    logic [CB-1:0] yw;
    xw = px[CB-1:0];
    yw = py[CB-1:0];
    return {yw, xw};
  endfunction

  // Run the midpoint loop for one circle and queue every iteration it gives.
  task automatic rasterize_circle(input logic signed [CENTER_BITS-1:0] cx_v,
                                  input logic signed [CENTER_BITS-1:0] cy_v,
                                  input logic [RB-1:0] rad);
    int           cx;
    int           cy;
    int           ox;
    int           oy;
    int           derr;
    int           n;
    circle_step_t s;
    cx   = cx_v;
    cy   = cy_v;
    ox   = rad;
    oy   = 0;
    derr = 0;
    n    = 0;
    while (ox >= oy && n < 64) begin
      s.pts[0] = pack_xy(cx + ox, cy + oy);
      s.pts[1] = pack_xy(cx + oy, cy + ox);
      s.pts[2] = pack_xy(cx - oy, cy + ox);
      s.pts[3] = pack_xy(cx - ox, cy + oy);
      s.pts[4] = pack_xy(cx - ox, cy - oy);
      s.pts[5] = pack_xy(cx - oy, cy - ox);
      s.pts[6] = pack_xy(cx + oy, cy - ox);
      s.pts[7] = pack_xy(cx + ox, cy - oy);
      // y step first, then the x step sees the updated error
      if (derr <= 0) begin
        oy   = oy + 1;
        derr = derr + 2 * oy + 1;
      end
      if (derr > 0) begin
        ox   = ox - 1;
        derr = derr - (2 * ox + 1);
      end
      s.last = (ox >= oy) ? 1'b0 : 1'b1;
      expected_steps.push_back(s);
      n++;
    end
  endtask

  // Present one request from the falling edge, idling first at random, and
  // hold it until the block takes it. The expected iterations are queued at
  // the edge of acceptance, ahead of the first result.
  task automatic send_circle(input logic signed [CENTER_BITS-1:0] cx_v,
                             input logic signed [CENTER_BITS-1:0] cy_v,
                             input logic [RB-1:0] rad);
    @(negedge clk);
    while (!steady_flow && $urandom_range(99) < 37) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid    <= 1'b1;
    req.center_x <= cx_v;
    req.center_y <= cy_v;
    req.radius   <= rad;
    do @(posedge clk); while (!req.ready);
    rasterize_circle(cx_v, cy_v, rad);
  endtask

  // Result side: stall at random unless the steady stretch is running.
  always @(negedge clk) begin
    if (!rst_n) begin
      res.ready <= 1'b0;
    end else if (steady_flow) begin
      res.ready <= 1'b1;
    end else begin
      res.ready <= ($urandom_range(99) >= 37);
    end
  end

  // Check each accepted result against the oldest queued iteration.
  always @(posedge clk) begin
    logic [NUM_POINTS-1:0][2*CB-1:0] got;
    circle_step_t                    want;
    if (rst_n && res.valid && res.ready) begin
      got[0] = res.point_0;
      got[1] = res.point_1;
      got[2] = res.point_2;
      got[3] = res.point_3;
      got[4] = res.point_4;
      got[5] = res.point_5;
      got[6] = res.point_6;
      got[7] = res.point_7;
      if (expected_steps.size() == 0) begin
        $error("unexpected result: point_0 %h last_step %b", got[0], res.last_step);
        fail_count++;
      end else begin
        want = expected_steps.pop_front();
        for (int k = 0; k < NUM_POINTS; k++) begin
          if (got[k] !== want.pts[k]) begin
            $error("point_%0d mismatch: expected %h, actual %h", k, want.pts[k], got[k]);
            fail_count++;
          end
        end
        if (res.last_step !== want.last) begin
          $error("last_step mismatch: expected %b, actual %b", want.last, res.last_step);
          fail_count++;
        end
      end
    end
  end

  // Zero radius: a single iteration with every point at the center.
  task automatic test_zero_radius();
    send_circle(12'sd0, 12'sd0, '0);
    send_circle(-12'sd2048, 12'sd2047, '0);
    send_circle(12'sd2047, -12'sd2048, '0);
    send_circle(-12'sd1, -12'sd1, '0);
  endtask

  // Extreme centers with the smallest and largest nonzero radius.
  task automatic test_corner_centers();
    send_circle(-12'sd2048, -12'sd2048, 6'd63);
    send_circle(12'sd2047, 12'sd2047, 6'd63);
    send_circle(-12'sd2048, 12'sd2047, 6'd1);
    send_circle(12'sd2047, -12'sd2048, 6'd1);
    send_circle(12'sd2047, 12'sd2047, 6'd1);
    send_circle(-12'sd2048, -12'sd2048, 6'd63);
    send_circle(12'sd0, 12'sd0, 6'd63);
    send_circle(-12'sd2048, 12'sd2047, 6'd63);
  endtask

  // Walk the small radii, where the loop ends after very few iterations.
  task automatic test_small_radii();
    for (int r = 1; r <= 8; r++) begin
      send_circle(12'($urandom_range(4095)), 12'($urandom_range(4095)), RB'(r));
    end
  endtask

  // Random centers and radii, under random idling on both sides unless steady_flow is set.
  task automatic test_random_circles(input int count);
    logic signed [CENTER_BITS-1:0] cx_v;
    logic signed [CENTER_BITS-1:0] cy_v;
    for (int i = 0; i < count; i++) begin
      cx_v = 12'($urandom_range(4095));
      cy_v = 12'($urandom_range(4095));
      // drop to an extreme center now and then
      if ($urandom_range(9) == 0) cx_v = $urandom_range(1) ? -12'sd2048 : 12'sd2047;
      if ($urandom_range(9) == 0) cy_v = $urandom_range(1) ? -12'sd2048 : 12'sd2047;
      send_circle(cx_v, cy_v, RB'($urandom_range(63)));
    end
  endtask

  // Back-to-back requests with the result side always ready.
  task automatic test_back_to_back(input int count);
    steady_flow = 1'b1;
    test_random_circles(count);
    steady_flow = 1'b0;
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    steady_flow  = 1'b0;
    fail_count   = 0;
    req.valid    = 1'b0;
    req.center_x = '0;
    req.center_y = '0;
    req.radius   = '0;
    res.ready    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_zero_radius();
    test_corner_centers();
    test_small_radii();
    test_random_circles(150);
    test_back_to_back(60);
    test_random_circles(110);

    @(negedge clk);
    req.valid <= 1'b0;
    // Drain the outstanding iterations, then keep clocking so that any stray result
    // still shows.
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
